/* src/calendar_clock_with_weekday_macros.svh */
// assertion helpers used by the calendar clock module
`ifndef CALENDAR_CLOCK_WITH_WEEKDAY_MACROS_SVH
`define CALENDAR_CLOCK_WITH_WEEKDAY_MACROS_SVH

// condition holds at every edge outside reset
`define CCW_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// trigger implies condition in the next cycle
`define CCW_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

/* src/ccw_pkg.sv */
`default_nettype none

package ccw_pkg;

   localparam int YEAR_W    = 7;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int SECOND_W  = 6;
   localparam int WEEKDAY_W = 3;

   // operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // limits of the calendar
   localparam logic [SECOND_W-1:0]  LAST_SECOND = 6'd59;
   localparam logic [MINUTE_W-1:0]  LAST_MINUTE = 6'd59;
   localparam logic [HOUR_W-1:0]    LAST_HOUR   = 5'd23;
   localparam logic [MONTH_W-1:0]   LAST_MONTH  = 4'd12;
   localparam logic [YEAR_W-1:0]    LAST_YEAR   = 7'd99;
   localparam logic [MONTH_W-1:0]   MONTH_JAN   = 4'd1;
   localparam logic [MONTH_W-1:0]   MONTH_FEB   = 4'd2;
   localparam logic [MONTH_W-1:0]   MONTH_MAR   = 4'd3;
   localparam logic [DAY_W-1:0]     FIRST_DAY   = 5'd1;
   localparam logic [WEEKDAY_W-1:0] RESET_WEEKDAY = 3'd6;

   typedef struct packed {
      logic [WEEKDAY_W-1:0] weekday;
      logic [DAY_W-1:0]     day;
      logic [MONTH_W-1:0]   month;
      logic [YEAR_W-1:0]    year;
      logic [HOUR_W-1:0]    hour;
      logic [MINUTE_W-1:0]  minute;
      logic [SECOND_W-1:0]  second;
   } ccw_time_type;

   // month length, every fourth year leap; unknown months read as january
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic [YEAR_W-1:0]  year);
      logic [DAY_W-1:0] len;
      unique case (month)
         4'd2:                      len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   // month offsets of the weekday formula
   function automatic logic [WEEKDAY_W-1:0] month_offset(input logic [MONTH_W-1:0] month);
      logic [WEEKDAY_W-1:0] ofs;
      unique case (month)
         4'd2:    ofs = 3'd3;
         4'd3:    ofs = 3'd2;
         4'd4:    ofs = 3'd5;
         4'd5:    ofs = 3'd0;
         4'd6:    ofs = 3'd3;
         4'd7:    ofs = 3'd5;
         4'd8:    ofs = 3'd1;
         4'd9:    ofs = 3'd4;
         4'd10:   ofs = 3'd6;
         4'd11:   ofs = 3'd2;
         4'd12:   ofs = 3'd4;
         default: ofs = 3'd0;
      endcase
      return ofs;
   endfunction

   // remainder by seven: fold octal digits, since eight is one mod seven
   function automatic logic [WEEKDAY_W-1:0] mod7(input logic [7:0] x);
      logic [4:0] a;
      logic [3:0] b;
      a = {2'b0, x[2:0]} + {2'b0, x[5:3]} + {3'b0, x[7:6]};
      b = {1'b0, a[2:0]} + {2'b0, a[4:3]};
      return (b >= 4'd7) ? 3'(b - 4'd7) : b[2:0];
   endfunction

   // weekday of a date in 2000..2099; within the century the century terms
   // cancel mod 7, and shifting the year by four keeps the quarter exact
   // for january and february of 2000 (which count as 1999)
   function automatic logic [WEEKDAY_W-1:0] weekday_of(input logic [DAY_W-1:0]   day,
                                                       input logic [MONTH_W-1:0] month,
                                                       input logic [YEAR_W-1:0]  year);
      logic [YEAR_W-1:0] t;
      logic [7:0]        sum;
      t   = year + 7'd4 - {6'd0, (month < MONTH_MAR)};
      sum = {1'b0, t} + {3'b0, t[6:2]} + 8'd2 + {5'b0, month_offset(month)}
            + {3'b0, day};
      return mod7(sum);
   endfunction

endpackage

`default_nettype wire

/* src/ccw_ifs.sv */
`default_nettype none

// load or tick beat
interface ccw_req_if;
   import ccw_pkg::*;
   logic                valid;
   logic                ready;
   logic                operation;
   logic [YEAR_W-1:0]   load_year;
   logic [MONTH_W-1:0]  load_month;
   logic [DAY_W-1:0]    load_day;
   logic [HOUR_W-1:0]   load_hour;
   logic [MINUTE_W-1:0] load_minute;
   logic [SECOND_W-1:0] load_second;
   modport source (output valid, operation, load_year, load_month, load_day,
                   load_hour, load_minute, load_second, input ready);
   modport sink   (input valid, operation, load_year, load_month, load_day,
                   load_hour, load_minute, load_second, output ready);
endinterface

// date and time beat
interface ccw_rsp_if;
   import ccw_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [WEEKDAY_W-1:0] out_weekday;
   logic [DAY_W-1:0]     out_day;
   logic [MONTH_W-1:0]   out_month;
   logic [YEAR_W-1:0]    out_year;
   logic [HOUR_W-1:0]    out_hour;
   logic [MINUTE_W-1:0]  out_minute;
   logic [SECOND_W-1:0]  out_second;
   modport source (output valid, out_weekday, out_day, out_month, out_year,
                   out_hour, out_minute, out_second, input ready);
   modport sink   (input valid, out_weekday, out_day, out_month, out_year,
                   out_hour, out_minute, out_second, output ready);
endinterface

// run control write
interface ccw_csr_if;
   logic valid;
   logic ready;
   logic clock_running;
   modport source (output valid, clock_running, input ready);
   modport sink   (input valid, clock_running, output ready);
endinterface

`default_nettype wire

/* src/calendar_clock_with_weekday.sv */
// Calendar clock for the years 2000 to 2099 (year held as year minus 2000).
// Each request beat is a one-second tick or a load of a full date and time;
// every accepted beat gives exactly one response beat with the date, time and
// weekday (0 = Sunday) after the beat is applied, or all zeros while the
// clock is stopped. Ticks are ignored while stopped; loads always apply, with
// each field clamped into its legal range (day clamped to the loaded month).
// The run bit is written through the csr channel, which is always ready, and
// should be changed only while no response is pending. The whole update is
// combinational between the state registers and the response register, so a
// request is taken every cycle; the response register is the only stage, and
// requests stall only while a response is held by the consumer.
`default_nettype none
`include "calendar_clock_with_weekday_macros.svh"

module calendar_clock_with_weekday (
   input  wire logic   clock,
   input  wire logic   reset,
   ccw_req_if.sink     req_ch,
   ccw_rsp_if.source   rsp_ch,
   ccw_csr_if.sink     csr_ch
);
   import ccw_pkg::*;

   logic         running_ff;
   ccw_time_type cur_ff, cur_in;
   ccw_time_type res_ff, res_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         req_accept;

   ccw_time_type tick_t, load_t;
   logic         day_roll;
   logic [DAY_W-1:0] load_dim;

   // handshakes
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // tick carry chain
   always_comb begin
      tick_t   = cur_ff;
      day_roll = 1'b0;
      if (cur_ff.second == LAST_SECOND) begin
         tick_t.second = '0;
         if (cur_ff.minute == LAST_MINUTE) begin
            tick_t.minute = '0;
            if (cur_ff.hour == LAST_HOUR) begin
               tick_t.hour = '0;
               day_roll    = 1'b1;
               if (cur_ff.day >= month_days(cur_ff.month, cur_ff.year)) begin
                  tick_t.day = FIRST_DAY;
                  if (cur_ff.month >= LAST_MONTH) begin
                     tick_t.month = MONTH_JAN;
                     tick_t.year  = (cur_ff.year >= LAST_YEAR) ? '0 : cur_ff.year + 7'd1;
                  end else begin
                     tick_t.month = cur_ff.month + 4'd1;
                  end
               end else begin
                  tick_t.day = cur_ff.day + 5'd1;
               end
            end else begin
               tick_t.hour = cur_ff.hour + 5'd1;
            end
         end else begin
            tick_t.minute = cur_ff.minute + 6'd1;
         end
      end else begin
         tick_t.second = cur_ff.second + 6'd1;
      end
      if (day_roll) begin
         tick_t.weekday = weekday_of(tick_t.day, tick_t.month, tick_t.year);
      end
   end

   // clamped load
   always_comb begin
      load_t.year   = (req_ch.load_year > LAST_YEAR) ? LAST_YEAR : req_ch.load_year;
      if (req_ch.load_month == '0) begin
         load_t.month = MONTH_JAN;
      end else if (req_ch.load_month > LAST_MONTH) begin
         load_t.month = LAST_MONTH;
      end else begin
         load_t.month = req_ch.load_month;
      end
      load_dim = month_days(load_t.month, load_t.year);
      if (req_ch.load_day == '0) begin
         load_t.day = FIRST_DAY;
      end else if (req_ch.load_day > load_dim) begin
         load_t.day = load_dim;
      end else begin
         load_t.day = req_ch.load_day;
      end
      load_t.hour    = (req_ch.load_hour > LAST_HOUR) ? LAST_HOUR : req_ch.load_hour;
      load_t.minute  = (req_ch.load_minute > LAST_MINUTE) ? LAST_MINUTE
                                                          : req_ch.load_minute;
      load_t.second  = (req_ch.load_second > LAST_SECOND) ? LAST_SECOND
                                                          : req_ch.load_second;
      load_t.weekday = weekday_of(load_t.day, load_t.month, load_t.year);
   end

   // next state and response
   always_comb begin
      cur_in       = cur_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (req_accept) begin
         case (req_ch.operation)
            OP_LOAD: cur_in = load_t;
            default: cur_in = running_ff ? tick_t : cur_ff;
         endcase
         res_in       = running_ff ? cur_in : '0;
         rsp_valid_in = 1'b1;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         cur_ff.second  <= '0;
         cur_ff.minute  <= '0;
         cur_ff.hour    <= '0;
         cur_ff.day     <= FIRST_DAY;
         cur_ff.month   <= MONTH_JAN;
         cur_ff.year    <= '0;
         cur_ff.weekday <= RESET_WEEKDAY;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         if (csr_ch.valid && csr_ch.ready) begin
            running_ff <= csr_ch.clock_running;
         end
      end
      res_ff <= res_in;
   end

   // response port
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_weekday = res_ff.weekday;
   assign rsp_ch.out_day     = res_ff.day;
   assign rsp_ch.out_month   = res_ff.month;
   assign rsp_ch.out_year    = res_ff.year;
   assign rsp_ch.out_hour    = res_ff.hour;
   assign rsp_ch.out_minute  = res_ff.minute;
   assign rsp_ch.out_second  = res_ff.second;

   // checks
   `CCW_ASSERT_ALWAYS(a_time_legal, clock, reset,
      cur_ff.second <= LAST_SECOND && cur_ff.minute <= LAST_MINUTE &&
      cur_ff.hour <= LAST_HOUR && cur_ff.year <= LAST_YEAR,
      "time of day or year out of range")
   `CCW_ASSERT_ALWAYS(a_date_legal, clock, reset,
      cur_ff.month >= MONTH_JAN && cur_ff.month <= LAST_MONTH && cur_ff.day >= FIRST_DAY &&
      cur_ff.day <= month_days(cur_ff.month, cur_ff.year),
      "date out of range")
   `CCW_ASSERT_ALWAYS(a_weekday_legal, clock, reset,
      cur_ff.weekday <= 3'd6, "weekday out of range")
   `CCW_ASSERT_NEXT(a_second_steps, clock, reset,
      req_accept && req_ch.operation == OP_TICK && running_ff &&
      cur_ff.second != LAST_SECOND,
      cur_ff.second == $past(cur_ff.second) + 6'd1 && cur_ff.minute == $past(cur_ff.minute),
      "running tick did not advance the second")

endmodule

`default_nettype wire
